[hdl/bba_pkg.sv]
// Shared types, codes and helpers of the bitmap block allocator.
package bba_pkg;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned ST_W        = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned SIZE_W      = 16;
  localparam int unsigned BCNT_W      = 6;
  localparam int unsigned IDX_OUT_W   = 5;
  localparam int unsigned CNT_OUT_W   = 6;
  localparam int unsigned DIGIT_W     = 8;
  localparam int unsigned DIGIT_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_ALIGN = 2'd3
  } st_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_OFF,
    S_RANGE,
    S_DIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic done;
    logic found;
  } scan_sts_t;

  typedef struct packed {
    logic done;
    logic exact;
  } div_sts_t;

  // position of the lowest set bit of one digit
  function automatic logic [DIGIT_IDX_W-1:0] lowest_set(input logic [DIGIT_W-1:0] v);
    logic [DIGIT_IDX_W-1:0] r;
    r = '0;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      if (v[i]) r = DIGIT_IDX_W'(i);
    end
    return r;
  endfunction

endpackage

[hdl/bba_req_if.sv]
// Request channel: opcode and release address.
interface bba_req_if #(
  parameter int unsigned ADDR_WIDTH = 32
);
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::OP_W-1:0]    opcode;
  logic [ADDR_WIDTH-1:0]       release_address;

  modport source (output valid, output opcode, output release_address, input ready);
  modport sink   (input valid, input opcode, input release_address, output ready);
endinterface

[hdl/bba_rsp_if.sv]
// Response channel: status, granted address, block index and used count.
interface bba_rsp_if #(
  parameter int unsigned ADDR_WIDTH = 32
);
  logic                            valid;
  logic                            ready;
  logic [bba_pkg::ST_W-1:0]        status;
  logic [ADDR_WIDTH-1:0]           granted_address;
  logic [bba_pkg::IDX_OUT_W-1:0]   slot_index;
  logic [bba_pkg::CNT_OUT_W-1:0]   used_count;

  modport source (output valid, output status, output granted_address,
                  output slot_index, output used_count, input ready);
  modport sink   (input valid, input status, input granted_address,
                  input slot_index, input used_count, output ready);
endinterface

[hdl/bba_cfg_if.sv]
// Configuration write channel: register index and write data.
interface bba_cfg_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                            valid;
  logic                            ready;
  logic [bba_pkg::CFG_IDX_W-1:0]   index;
  logic [DATA_WIDTH-1:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/bba_scan.sv]
// Digit-serial search for the lowest free block, one 8-bit digit per cycle.
module bba_scan #(
  parameter int unsigned MAX_BLOCKS = 32,
  parameter int unsigned IDX_W      = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [MAX_BLOCKS-1:0]      free_i,
  output bba_pkg::scan_sts_t         sts_o,
  output logic [IDX_W-1:0]           idx_o
);
  import bba_pkg::*;

  localparam int unsigned NumDig = (MAX_BLOCKS + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned ShW    = NumDig * DIGIT_W;
  localparam int unsigned DigW   = (NumDig > 1) ? $clog2(NumDig) : 1;
  localparam int unsigned PosW   = DigW + DIGIT_IDX_W;

  logic [ShW-1:0]     sh_q;
  logic [DigW-1:0]    dig_q;
  logic               busy_q;
  logic [DIGIT_W-1:0] low;
  logic               hit;
  logic               last;
  logic [PosW-1:0]    pos;

  assign low  = sh_q[DIGIT_W-1:0];
  assign hit  = |low;
  assign last = (dig_q == DigW'(NumDig - 1));
  assign pos  = {dig_q, lowest_set(low)};

  always_comb begin
    sts_o.done  = busy_q && (hit || last);
    sts_o.found = busy_q && hit;
    idx_o       = pos[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (sts_o.done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= ShW'(free_i);
      dig_q <= '0;
    end else if (busy_q && !hit && !last) begin
      sh_q  <= sh_q >> DIGIT_W;
      dig_q <= dig_q + DigW'(1);
    end
  end

endmodule

[hdl/bba_div.sv]
// Bit-serial restoring divider: block index and alignment check of a freed address.
module bba_div #(
  parameter int unsigned QW = 5,
  parameter int unsigned NW = 22,
  parameter int unsigned DW = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NW-1:0]      dividend_i,
  input  logic [DW-1:0]      divisor_i,
  output bba_pkg::div_sts_t  sts_o,
  output logic [QW-1:0]      quot_o
);
  import bba_pkg::*;

  localparam int unsigned StW = $clog2(QW + 1);

  logic [NW-1:0]  rem_q;
  logic [NW-1:0]  dsr_q;
  logic [QW-1:0]  quot_q;
  logic [StW-1:0] steps_q;
  logic           busy_q;
  logic           ge;

  assign ge = (rem_q >= dsr_q);

  always_comb begin
    sts_o.done  = busy_q && (steps_q == '0);
    sts_o.exact = (rem_q == '0);
    quot_o      = quot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      steps_q <= '0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      steps_q <= StW'(QW);
    end else if (busy_q) begin
      if (steps_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        steps_q <= steps_q - StW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dsr_q  <= NW'(divisor_i) << (QW - 1);
      quot_q <= '0;
    end else if (busy_q && (steps_q != '0)) begin
      if (ge) rem_q <= rem_q - dsr_q;
      dsr_q  <= dsr_q >> 1;
      quot_q <= QW'({quot_q, ge});
    end
  end

endmodule

[hdl/bitmap_block_allocator_unit.sv]
// Top level of the bitmap block allocator: control, allocation map and response register.
//
// Channels: req (opcode, release_address), rsp (status, granted_address,
// slot_index, used_count) and cfg (register writes, always ready). A transaction
// moves on a channel at a clock edge with valid and ready both high.
// One request is worked on at a time; req.ready is high only while idle.
// Allocate scans the free-block mask one 8-bit digit per cycle, then multiplies
// the index by the block size in S_MUL before the result is registered in S_OUT;
// a full pool goes from the scan straight to S_OUT.
// Free subtracts the base, checks the pool span, then runs a bit-serial divide,
// one quotient bit per cycle; an address outside the pool skips the divide.
// Clear and the idle opcode go from the request straight to S_OUT. req.ready
// returns in the cycle after the response register is loaded.
// A finished response sits in the output register; the block takes the next
// request while it waits there, and holds a further result until rsp.ready.
// Reset empties the map, zeroes the used count and loads the register defaults:
// base 0, block size 1, block count 32. Register writes leave the map alone.
module bitmap_block_allocator_unit #(
  parameter int unsigned MAX_BLOCKS = 32,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bba_req_if.sink    req,
  bba_rsp_if.source  rsp,
  bba_cfg_if.sink    cfg
);
  import bba_pkg::*;

  localparam int unsigned IdxW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SpanW = CntW + SIZE_W;
  localparam int unsigned CmpW  = (ADDR_WIDTH > SpanW) ? ADDR_WIDTH : SpanW;
  localparam int unsigned ProdW = IdxW + SIZE_W;
  localparam int unsigned GntW  = (ADDR_WIDTH > ProdW) ? ADDR_WIDTH : ProdW;
  localparam int unsigned BcW   = (CntW > BCNT_W) ? CntW : BCNT_W;

  state_e                state_q, state_d;
  logic [ADDR_WIDTH-1:0] base_q;
  logic [SIZE_W-1:0]     size_q;
  logic [BCNT_W-1:0]     bcnt_q;
  logic [MAX_BLOCKS-1:0] map_q;
  logic [CntW-1:0]       cnt_q;

  logic [ADDR_WIDTH-1:0] addr_q;
  logic [ADDR_WIDTH-1:0] off_q;
  logic [SpanW-1:0]      span_q;
  logic [ProdW-1:0]      prod_q;
  logic [IdxW-1:0]       idx_q;
  st_e                   st_q;
  logic                  gnt_ok_q;

  logic                  rsp_valid_q;
  logic [ST_W-1:0]       rsp_status_q;
  logic [ADDR_WIDTH-1:0] rsp_gnt_q;
  logic [IDX_OUT_W-1:0]  rsp_idx_q;
  logic [CNT_OUT_W-1:0]  rsp_cnt_q;

  logic                  accept;
  op_e                   op;
  logic                  scan_start;
  logic                  div_start;
  logic                  out_load;
  logic                  in_range;
  logic [BcW-1:0]        bc_ext;
  logic [CntW-1:0]       eff_cnt;
  logic [MAX_BLOCKS-1:0] free_vec;
  scan_sts_t             scan_sts;
  logic [IdxW-1:0]       scan_idx;
  div_sts_t              div_sts;
  logic [IdxW-1:0]       div_quot;
  logic [CmpW-1:0]       off_ext;
  logic [GntW-1:0]       gsum;
  logic [IdxW+IDX_OUT_W-1:0] idx_wide;
  logic [CntW+CNT_OUT_W-1:0] cnt_wide;

  assign op      = op_e'(req.opcode);
  assign bc_ext  = BcW'(bcnt_q);
  assign eff_cnt = (bc_ext > BcW'(MAX_BLOCKS)) ? CntW'(MAX_BLOCKS) : bc_ext[CntW-1:0];
  assign off_ext = CmpW'(off_q);
  assign in_range = (size_q != '0) && (off_ext < CmpW'(span_q));
  assign gsum     = GntW'(base_q) + GntW'(prod_q);
  assign idx_wide = (IdxW + IDX_OUT_W)'(idx_q);
  assign cnt_wide = (CntW + CNT_OUT_W)'(cnt_q);

  always_comb begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      free_vec[i] = !map_q[i] && (CntW'(i) < eff_cnt);
    end
  end

  bba_scan #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .IDX_W      (IdxW)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .free_i  (free_vec),
    .sts_o   (scan_sts),
    .idx_o   (scan_idx)
  );

  bba_div #(
    .QW (IdxW),
    .NW (SpanW),
    .DW (SIZE_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (off_ext[SpanW-1:0]),
    .divisor_i  (size_q),
    .sts_o      (div_sts),
    .quot_o     (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_ALLOC: state_d = S_SCAN;
            OP_FREE:  state_d = S_OFF;
            OP_CLEAR,
            OP_NOP:   state_d = S_OUT;
            default:  state_d = S_OUT;
          endcase
        end
      end
      S_SCAN:  if (scan_sts.done) state_d = scan_sts.found ? S_MUL : S_OUT;
      S_MUL:   state_d = S_OUT;
      S_OFF:   state_d = S_RANGE;
      S_RANGE: state_d = in_range ? S_DIV : S_OUT;
      S_DIV:   if (div_sts.done) state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req.ready  = (state_q == S_IDLE);
    accept     = req.valid && req.ready;
    scan_start = accept && (op == OP_ALLOC);
    div_start  = (state_q == S_RANGE) && in_range;
    out_load   = (state_q == S_OUT) && (!rsp_valid_q || rsp.ready);
  end

  assign cfg.ready           = 1'b1;
  assign rsp.valid           = rsp_valid_q;
  assign rsp.status          = rsp_status_q;
  assign rsp.granted_address = rsp_gnt_q;
  assign rsp.slot_index      = rsp_idx_q;
  assign rsp.used_count      = rsp_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      size_q      <= SIZE_W'(1);
      bcnt_q      <= BCNT_W'(32);
      map_q       <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          CFG_POOL_BASE:   base_q <= cfg.data[ADDR_WIDTH-1:0];
          CFG_BLOCK_SIZE:  size_q <= cfg.data[SIZE_W-1:0];
          CFG_BLOCK_COUNT: bcnt_q <= cfg.data[BCNT_W-1:0];
          default: ;
        endcase
      end
      if (accept && (op == OP_CLEAR)) begin
        map_q <= '0;
        cnt_q <= '0;
      end
      if ((state_q == S_SCAN) && scan_sts.found) begin
        map_q[scan_idx] <= 1'b1;
        cnt_q           <= cnt_q + CntW'(1);
      end
      if ((state_q == S_DIV) && div_sts.done && div_sts.exact) begin
        map_q[div_quot] <= 1'b0;
        if (map_q[div_quot]) cnt_q <= cnt_q - CntW'(1);
      end
      if (out_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q   <= req.release_address;
      st_q     <= ST_OK;
      idx_q    <= '0;
      gnt_ok_q <= 1'b0;
    end
    if ((state_q == S_SCAN) && scan_sts.done) begin
      if (scan_sts.found) begin
        idx_q    <= scan_idx;
        gnt_ok_q <= 1'b1;
      end else begin
        st_q <= ST_FULL;
      end
    end
    if (state_q == S_MUL) prod_q <= ProdW'(idx_q) * ProdW'(size_q);
    if (state_q == S_OFF) begin
      off_q  <= addr_q - base_q;
      span_q <= SpanW'(eff_cnt) * SpanW'(size_q);
    end
    if ((state_q == S_RANGE) && !in_range) st_q <= ST_RANGE;
    if ((state_q == S_DIV) && div_sts.done) begin
      if (div_sts.exact) idx_q <= div_quot;
      else               st_q  <= ST_ALIGN;
    end
    if (out_load) begin
      rsp_status_q <= st_q;
      rsp_gnt_q    <= gnt_ok_q ? gsum[ADDR_WIDTH-1:0] : '0;
      rsp_idx_q    <= idx_wide[IDX_OUT_W-1:0];
      rsp_cnt_q    <= cnt_wide[CNT_OUT_W-1:0];
    end
  end

endmodule

[hdl/bba_checker.sv]
// Port-level assertions of the bitmap block allocator, bound to the top level.
module bba_checker #(
  parameter int unsigned MAX_BLOCKS = 32,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                req_valid_i,
  input logic                                req_ready_i,
  input logic                                rsp_valid_i,
  input logic                                rsp_ready_i,
  input logic [bba_pkg::ST_W-1:0]            status_i,
  input logic [ADDR_WIDTH-1:0]               granted_address_i,
  input logic [bba_pkg::IDX_OUT_W-1:0]       slot_index_i,
  input logic [bba_pkg::CNT_OUT_W-1:0]       used_count_i
);
  import bba_pkg::*;

  localparam int unsigned CmpW = CNT_OUT_W + 1;

  // one request in flight: ready drops right after a transaction
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request accepted while busy");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(status_i) &&
      $stable(granted_address_i) && $stable(slot_index_i) && $stable(used_count_i)))
    else $error("stalled response changed");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (status_i != ST_OK)) |-> ((slot_index_i == '0) &&
      (granted_address_i == '0)))
    else $error("error response with nonzero index or address");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> ((MAX_BLOCKS > 63) || (CmpW'(used_count_i) <= CmpW'(MAX_BLOCKS))))
    else $error("used count above pool size");

endmodule

bind bitmap_block_allocator_unit bba_checker #(
  .MAX_BLOCKS (MAX_BLOCKS),
  .ADDR_WIDTH (ADDR_WIDTH)
) u_bba_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req.valid),
  .req_ready_i       (req.ready),
  .rsp_valid_i       (rsp.valid),
  .rsp_ready_i       (rsp.ready),
  .status_i          (rsp.status),
  .granted_address_i (rsp.granted_address),
  .slot_index_i      (rsp.slot_index),
  .used_count_i      (rsp.used_count)
);
